FILE: sv/assert_macros.svh
// Assertion macros shared by the list RTL.
// Depends on nothing; the assertion forms compile only when SYNTH is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/isl_pkg.sv
// Shared types, sizes and helpers for the indexed sequence list.
// Used by the storage cell, the controller and the top level.
`timescale 1ns / 1ps

package isl_pkg;

   localparam int CAPACITY    = 32;
   localparam int ELEM_BITS   = 32;
   localparam int OP_BITS     = 3;
   localparam int POS_BITS    = 6;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_BITS    = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND    = 3'd0,
      OP_PREPEND   = 3'd1,
      OP_INSERT    = 3'd2,
      OP_REMOVE_AT = 3'd3,
      OP_TAKE_HEAD = 3'd4,
      OP_TAKE_TAIL = 3'd5,
      OP_READ      = 3'd6,
      OP_CLEAR     = 3'd7
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_NONE = 2'd0,
      SHIFT_INS  = 2'd1,
      SHIFT_REM  = 2'd2
   } shift_type;

   typedef logic [ELEM_BITS-1:0] elem_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      shift_type              kind;
      logic [IDX_BITS-1:0]    pos;
      elem_type               value;
   } cell_cmd_type;

   // Result side of one transaction, from the controller to the output stage.
   typedef struct packed {
      status_type             status;
      logic [COUNT_BITS-1:0]  count;
      logic                   rd_en;
      logic [IDX_BITS-1:0]    rd_idx;
   } rsp_info_type;

   function automatic logic [VALUE_BITS-1:0] sign_extend(input elem_type e);
      logic signed [63:0] w;
      w = 64'($signed(e));
      return w[VALUE_BITS-1:0];
   endfunction

endpackage

FILE: sv/indexed_sequence_list.sv
// Top level of the indexed sequence list: stream ports, cell chain, output register.
// Depends on isl_pkg, isl_ctrl, isl_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bounded ordered list of up to CAPACITY signed elements kept in a row of
// storage cells. The result of a transaction is registered in the output
// register in the cycle after it is accepted, and a new transaction can be
// accepted every cycle while the result side keeps up.
// Insert and remove move all later elements by one place in that same cycle,
// each cell taking its neighbor's element; read, remove and pop select the
// addressed cell through one CAPACITY-to-one multiplexer. Errors (full,
// empty, position out of range) return a status with a zero value and leave
// the list unchanged. Reset empties the list at once; there is no clearing
// pass, and element storage is not reset.

module indexed_sequence_list
   import isl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position[5:0], element_value[37:6], zero fill
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // read_value[31:0], element_count[37:32], zero fill
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   logic                  accept;
   op_type                operation;
   cell_cmd_type          cmd;
   rsp_info_type          info;
   elem_type              cell_data [CAPACITY];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [VALUE_BITS-1:0] rsp_value_in;
   status_type            rsp_status_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                  clear_taken;
   logic                  clear_result_ok;
   logic                  err_value_zero;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign operation  = op_type'(req_tuser);

   isl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (operation),
      .position      (req_tdata[5:0]),
      .element_value (req_tdata[37:6]),
      .cmd           (cmd),
      .info          (info)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      elem_type left_data;
      elem_type right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      isl_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_BITS'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign rsp_value_in = info.rd_en ? sign_extend(cell_data[info.rd_idx]) : '0;

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= info.status;
         rsp_count_ff  <= info.count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, 6'(rsp_count_ff), rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign clear_taken     = accept && (operation == OP_CLEAR);
   assign clear_result_ok = (rsp_count_ff == '0) && (rsp_status_ff == ST_OK);
   assign err_value_zero  = !rsp_valid_ff || rsp_status_ff == ST_OK || rsp_value_ff == '0;

   `ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp_valid_ff)
   `ASSERT_NEXT(a_clear_empties, clock, reset, clear_taken, clear_result_ok)
   `ASSERT_ALWAYS(a_error_zero, clock, reset, err_value_zero)
   `ASSERT_ALWAYS(a_count_bound, clock, reset, !rsp_valid_ff || rsp_count_ff <= COUNT_BITS'(CAPACITY))

endmodule

FILE: sv/isl_cell.sv
// One storage cell of the element chain: holds, loads, or takes a neighbor's element.
// Depends on isl_pkg for the command struct and element type.
`timescale 1ns / 1ps

module isl_cell
   import isl_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_BITS-1:0] cell_index,
   input  cell_cmd_type        cmd,
   input  elem_type            left_data,
   input  elem_type            right_data,
   output elem_type            data
);

   elem_type data_ff;
   elem_type data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         SHIFT_INS: begin
            if (cell_index == cmd.pos) begin
               data_in = cmd.value;
            end else if (cell_index > cmd.pos) begin
               data_in = left_data;
            end
         end
         SHIFT_REM: begin
            // later elements move one place toward the front
            if (cell_index >= cmd.pos) begin
               data_in = right_data;
            end
         end
         SHIFT_NONE: begin
            data_in = data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: sv/isl_ctrl.sv
// List controller: element count, operation decode, status and chain command.
// Depends on isl_pkg for operation, status and command types.
`timescale 1ns / 1ps

module isl_ctrl
   import isl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  op_type                operation,
   input  logic [POS_BITS-1:0]   position,
   input  logic [VALUE_BITS-1:0] element_value,
   output cell_cmd_type          cmd,
   output rsp_info_type          info
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [CMP_BITS-1:0]   pos_c;
   logic [CMP_BITS-1:0]   cnt_c;
   logic                  full;
   logic                  empty;
   status_type            status;
   shift_type             kind;
   logic [IDX_BITS-1:0]   shift_pos;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_idx;

   assign pos_c = CMP_BITS'(position);
   assign cnt_c = CMP_BITS'(count_ff);
   assign full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      status    = ST_OK;
      kind      = SHIFT_NONE;
      shift_pos = '0;
      count_in  = count_ff;
      rd_en     = 1'b0;
      rd_idx    = '0;
      unique case (operation)
         OP_APPEND, OP_PREPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               kind      = SHIFT_INS;
               shift_pos = (operation == OP_APPEND) ? IDX_BITS'(count_ff) : '0;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else if (pos_c > cnt_c) begin
               status = ST_RANGE;
            end else begin
               kind      = SHIFT_INS;
               shift_pos = IDX_BITS'(pos_c);
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         OP_REMOVE_AT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (pos_c >= cnt_c) begin
               status = ST_RANGE;
            end else begin
               kind      = SHIFT_REM;
               shift_pos = IDX_BITS'(pos_c);
               rd_en     = 1'b1;
               rd_idx    = IDX_BITS'(pos_c);
               count_in  = count_ff - COUNT_BITS'(1);
            end
         end
         OP_TAKE_HEAD, OP_TAKE_TAIL: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               // a back pop needs no shift: dropping the count is enough
               kind      = (operation == OP_TAKE_HEAD) ? SHIFT_REM : SHIFT_NONE;
               rd_en     = 1'b1;
               rd_idx    = (operation == OP_TAKE_HEAD) ? '0
                           : IDX_BITS'(count_ff - COUNT_BITS'(1));
               count_in  = count_ff - COUNT_BITS'(1);
            end
         end
         OP_READ: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (pos_c >= cnt_c) begin
               status = ST_RANGE;
            end else begin
               rd_en  = 1'b1;
               rd_idx = IDX_BITS'(pos_c);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // hold the chain unless a transaction is taken
   assign cmd.kind    = accept ? kind : SHIFT_NONE;
   assign cmd.pos     = shift_pos;
   assign cmd.value   = ELEM_BITS'(element_value);

   assign info.status = status;
   assign info.count  = count_in;
   assign info.rd_en  = rd_en;
   assign info.rd_idx = rd_idx;

endmodule
